>>> sv/rlpc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the rotating LED PWM chaser.
// No dependencies; imported by every module of the block.
package rlpc_pkg;

    localparam int LED_W         = 8;   // width of the LED output field
    localparam int DUTY_W        = 5;   // width of one brightness entry and of the PWM counter
    localparam int POS_W         = 3;   // rotation phase width
    localparam int TABLE_ENTRIES = 8;
    localparam int TABLE_W       = TABLE_ENTRIES * DUTY_W;
    localparam int SPEED_W       = 8;
    localparam int DB_W          = 6;   // debounce counter width

    localparam logic [TABLE_W-1:0] TABLE_RESET = 40'd1145286303;

    // kind of tick carried in tuser
    localparam logic CMD_PWM = 1'b0;
    localparam logic CMD_SYS = 1'b1;

    typedef enum logic [1:0] {
        BTN_WAIT_PRESS   = 2'd0,
        BTN_PRESS_DB     = 2'd1,
        BTN_WAIT_RELEASE = 2'd2,
        BTN_RELEASE_DB   = 2'd3
    } btn_phase_t;

    // rotation state handed from the tick controller to the PWM stage
    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic             dir_down;
    } rlpc_phase_t;

endpackage

>>> sv/rlpc_ctrl.sv
`timescale 1ns / 1ps
// System-tick controller: rotation delay counter and button debounce machine.
// Depends on rlpc_pkg.
module rlpc_ctrl
    import rlpc_pkg::*;
#(
    parameter int DEBOUNCE_TICKS = 40
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,            // system tick in the result stage
    input  logic               button_level,  // 0 = pressed
    input  logic [SPEED_W-1:0] speed,
    output rlpc_phase_t        phase
);

    localparam logic [DB_W-1:0] DB_LIMIT = DB_W'(DEBOUNCE_TICKS);

    btn_phase_t         state_reg, state_next;
    logic [DB_W-1:0]    cnt_reg, cnt_next, cnt_inc;
    logic [SPEED_W-1:0] rw_reg, rw_next, rw_inc;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic               dir_reg, dir_next;
    logic               pressed;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BTN_WAIT_PRESS;
            cnt_reg   <= '0;
            rw_reg    <= '0;
            pos_reg   <= '0;
            dir_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            rw_reg    <= rw_next;
            pos_reg   <= pos_next;
            dir_reg   <= dir_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rw_next    = rw_reg;
        pos_next   = pos_reg;
        dir_next   = dir_reg;
        pressed    = ~button_level;
        cnt_inc    = cnt_reg + 1'b1;
        rw_inc     = rw_reg + 1'b1;
        if (en) begin
            // speed 255 never advances: the 8-bit count wraps before exceeding it
            if (rw_inc > speed) begin
                pos_next = pos_reg + 1'b1;
                rw_next  = '0;
            end else begin
                rw_next  = rw_inc;
            end

            case (state_reg)
                BTN_WAIT_PRESS: begin
                    if (pressed) begin
                        state_next = BTN_PRESS_DB;
                        cnt_next   = '0;
                    end
                end
                BTN_PRESS_DB: begin
                    if (cnt_inc >= DB_LIMIT) begin
                        cnt_next = '0;
                        if (pressed) begin
                            dir_next   = ~dir_reg;
                            state_next = BTN_WAIT_RELEASE;
                        end else begin
                            state_next = BTN_WAIT_PRESS;
                        end
                    end else begin
                        cnt_next = cnt_inc;
                    end
                end
                BTN_WAIT_RELEASE: begin
                    if (!pressed) begin
                        state_next = BTN_RELEASE_DB;
                        cnt_next   = '0;
                    end
                end
                BTN_RELEASE_DB: begin
                    if (cnt_inc >= DB_LIMIT) begin
                        cnt_next   = '0;
                        state_next = pressed ? BTN_WAIT_RELEASE : BTN_WAIT_PRESS;
                    end else begin
                        cnt_next = cnt_inc;
                    end
                end
                default: begin
                    state_next = BTN_WAIT_PRESS;
                    cnt_next   = '0;
                end
            endcase
        end
    end

    assign phase.pos      = pos_reg;
    assign phase.dir_down = dir_reg;

    a_wait_cnt_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BTN_WAIT_PRESS || state_reg == BTN_WAIT_RELEASE) |-> cnt_reg == '0)
        else $error("debounce count not cleared in a wait phase");

    a_dir_flip_src: assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(dir_reg) |-> ($past(state_reg) == BTN_PRESS_DB && $past(en)))
        else $error("direction changed outside a confirmed press");

    a_step_clears_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(pos_reg) |-> rw_reg == '0)
        else $error("rotation wait count not cleared on a step");

endmodule

>>> sv/rlpc_pwm.sv
`timescale 1ns / 1ps
// PWM counter and per-LED duty compare against the rotated brightness table.
// Depends on rlpc_pkg.
module rlpc_pwm
    import rlpc_pkg::*;
#(
    parameter int LED_COUNT = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,          // PWM tick in the result stage
    input  logic [TABLE_W-1:0] table_bits,
    input  rlpc_phase_t        phase,
    output logic [LED_W-1:0]   led_levels   // LED levels after this item
);

    logic [DUTY_W-1:0] pwm_reg, pwm_next;
    logic [LED_W-1:0]  led_reg, led_next, led_cmp;
    logic [DUTY_W:0]   level;               // counter + 1, range 1..32
    logic [DUTY_W-1:0] duty [TABLE_ENTRIES];
    logic [POS_W-1:0]  idx  [LED_W];

    for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_duty
        assign duty[k] = table_bits[k*DUTY_W +: DUTY_W];
    end

    always_comb begin
        level = {1'b0, pwm_reg} + 1'b1;
        for (int i = 0; i < LED_W; i++) begin
            idx[i] = phase.dir_down ? (phase.pos - POS_W'(i)) : (phase.pos + POS_W'(i));
            if (i < LED_COUNT) begin
                led_cmp[i] = (level <= {1'b0, duty[idx[i]]});
            end else begin
                led_cmp[i] = 1'b0;
            end
        end
        pwm_next = en ? level[DUTY_W-1:0] : pwm_reg;
        led_next = en ? led_cmp : led_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pwm_reg <= '0;
            led_reg <= '0;
        end else begin
            pwm_reg <= pwm_next;
            led_reg <= led_next;
        end
    end

    assign led_levels = led_next;

    a_pwm_only_on_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(pwm_reg) |-> $past(en))
        else $error("PWM counter moved without a PWM tick");

endmodule

>>> sv/rotating_led_pwm_chaser_unit.sv
`timescale 1ns / 1ps
// Top level of the rotating LED PWM chaser: input register, tick logic, result register.
// Depends on rlpc_pkg, rlpc_ctrl and rlpc_pwm.
//
// Eight-channel running-light PWM driver. Each input beat is a PWM tick or a
// system tick; every beat yields exactly one result beat carrying the LED levels
// after that tick. One beat is accepted per clock; each beat passes through the
// input register and then the result register, with all tick logic (duty compare,
// rotation counter, debounce machine) in the single stage between them.
// Backpressure on m_tready stalls both stages. The brightness table is written over
// the APB port at byte address 0 (64-bit data, low 40 bits used) and should only be
// changed while no beats are in flight.
module rotating_led_pwm_chaser_unit
    import rlpc_pkg::*;
#(
    parameter int LED_COUNT      = 8,
    parameter int DEBOUNCE_TICKS = 40
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [0] button_level, [8:1] speed, [15:9] zero
    input  logic        s_tuser,   // [0] command
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] led_levels
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    logic               in_valid_reg, in_valid_next;
    logic               in_cmd_reg;
    logic               in_btn_reg;
    logic [SPEED_W-1:0] in_speed_reg;
    logic               out_valid_reg, out_valid_next;
    logic [LED_W-1:0]   out_led_reg;
    logic [TABLE_W-1:0] table_reg;
    logic               advance, s_fire, fire, cfg_wr;
    logic [LED_W-1:0]   led_levels;
    rlpc_phase_t        phase;

    // result stage moves when the output slot is free or being drained
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = advance || !in_valid_reg;
    assign s_fire   = s_tvalid && s_tready;
    assign fire     = in_valid_reg && advance;

    always_comb begin
        in_valid_next  = advance ? s_fire : (in_valid_reg || s_fire);
        out_valid_next = advance ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_cmd_reg   <= s_tuser;
            in_btn_reg   <= s_tdata[0];
            in_speed_reg <= s_tdata[SPEED_W:1];
        end
        if (fire) begin
            out_led_reg <= led_levels;
        end
    end

    rlpc_ctrl #(
        .DEBOUNCE_TICKS (DEBOUNCE_TICKS)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (fire && in_cmd_reg == CMD_SYS),
        .button_level (in_btn_reg),
        .speed        (in_speed_reg),
        .phase        (phase)
    );

    rlpc_pwm #(
        .LED_COUNT (LED_COUNT)
    ) u_pwm (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (fire && in_cmd_reg == CMD_PWM),
        .table_bits (table_reg),
        .phase      (phase),
        .led_levels (led_levels)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_led_reg;

    // single register at byte address 0; paddr[3] set is beyond the map
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && !paddr[3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            table_reg <= TABLE_RESET;
        end else if (cfg_wr) begin
            table_reg <= pwdata[TABLE_W-1:0];
        end
    end

    assign prdata = paddr[3] ? 64'd0 : {{(64 - TABLE_W){1'b0}}, table_reg};

endmodule
